// ----- design/gir_pkg.sv -----
// gir_pkg: shared types, constants and helpers of the gf2 row echelon block
// no dependencies; imported by every module of the block

package gir_pkg;

  localparam int NUM_VARS = 32;
  localparam int IDX_W    = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int CNT_W    = $clog2(NUM_VARS + 1);
  localparam int FIELD_W  = 32;
  localparam int RANK_W   = 6;
  localparam int LOW_W    = (NUM_VARS < FIELD_W) ? NUM_VARS : FIELD_W;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } gir_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_PIVOT,
    ST_BACK,
    ST_INS,
    ST_DONE
  } gir_state_e;

  typedef logic [NUM_VARS-1:0] gir_row_t;

  typedef struct packed {
    gir_op_e              opcode;
    logic [FIELD_W-1:0]   row_bits;
    logic                 rhs_bit;
  } gir_req_t;

  typedef struct packed {
    logic                 consistent;
    logic                 new_pivot;
    logic [RANK_W-1:0]    rank;
    logic [FIELD_W-1:0]   solution;
  } gir_rsp_t;

  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    gir_row_t             wdata;
    logic [IDX_W-1:0]     raddr;
  } gir_mem_req_t;

  function automatic gir_row_t to_row(logic [FIELD_W-1:0] bits);
    gir_row_t r;
    r = '0;
    for (int i = 0; i < LOW_W; i++) begin
      r[i] = bits[i];
    end
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(gir_row_t r);
    logic [FIELD_W-1:0] f;
    f = '0;
    for (int i = 0; i < LOW_W; i++) begin
      f[i] = r[i];
    end
    return f;
  endfunction

  function automatic logic [IDX_W-1:0] onehot_idx(gir_row_t oh);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < NUM_VARS; i++) begin
      if (oh[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- design/gf2_incremental_row_echelon.sv -----
// gf2_incremental_row_echelon: top level, sequencer, row store and result register
// depends on gir_pkg, gir_row_mem and gir_ctrl

// Keeps a reduced row echelon system of parity equations over GF(2) with one
// stored row per pivot column. An add request is reduced against the store in
// a forward pass that reads one stored row per cycle; an independent row then
// back-reduces the store in a second read-modify-write pass and is inserted.
// A clear request empties the store. Each request yields one result with the
// consistency flag, the new-pivot flag, the rank and a solution with free
// variables at zero. An independent add makes both passes over the row
// memory; a dependent add skips the second pass, and a clear goes straight
// to the result. One request is worked on at a time; the next one is taken
// the cycle after its result enters the result register, so the result
// register lets the next request enter while a result waits.

module gf2_incremental_row_echelon import gir_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gir_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gir_rsp_t out_rsp_o
);

  gir_mem_req_t mem_req;
  gir_row_t     rdata;
  logic         res_valid;
  logic         res_ready;
  gir_rsp_t     res;
  logic         out_valid_q;
  gir_rsp_t     out_rsp_q;

  assign res_ready = !out_valid_q || !out_stall_i;

  gir_row_mem u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  gir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_stall_o (in_stall_o),
    .req_i       (in_req_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .rdata_i     (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ----- design/gir_row_mem.sv -----
// gir_row_mem: synchronous pivot row store, one write and one read port
// depends on gir_pkg

module gir_row_mem import gir_pkg::*; (
  input  logic         clk_i,
  input  gir_mem_req_t mem_req_i,
  output gir_row_t     rdata_o
);

  gir_row_t mem_q [NUM_VARS];
  gir_row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    rdata_q <= mem_q[mem_req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/gir_ctrl.sv -----
// gir_ctrl: elimination sequencer, forward pass, back-reduce pass and insert
// depends on gir_pkg; drives gir_row_mem through a gir_mem_req_t struct

module gir_ctrl import gir_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  output logic         req_stall_o,
  input  gir_req_t     req_i,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output gir_rsp_t     res_o,
  output gir_mem_req_t mem_req_o,
  input  gir_row_t     rdata_i
);

  gir_state_e             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  gir_row_t               row_q, row_d;
  logic                   b_q, b_d;
  gir_row_t               lead_q, lead_d;
  gir_row_t               present_q, present_d;
  gir_row_t               rhs_q, rhs_d;
  logic [CNT_W-1:0]       rank_q, rank_d;
  logic                   cons_q, cons_d;
  logic                   added_q, added_d;
  logic [IDX_W-1:0]       pidx;
  logic                   last;

  assign pidx = IDX_W'(cnt_q - 1'b1);
  assign last = (cnt_q == CNT_W'(NUM_VARS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      present_q <= '0;
      rhs_q     <= '0;
      rank_q    <= '0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      rhs_q     <= rhs_d;
      rank_q    <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    row_q   <= row_d;
    b_q     <= b_d;
    lead_q  <= lead_d;
    cons_q  <= cons_d;
    added_q <= added_d;
  end

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    row_d           = row_q;
    b_d             = b_q;
    lead_d          = lead_q;
    present_d       = present_q;
    rhs_d           = rhs_q;
    rank_d          = rank_q;
    cons_d          = cons_q;
    added_d         = added_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = pidx;
    mem_req_o.wdata = row_q ^ rdata_i;
    mem_req_o.raddr = IDX_W'(cnt_q);
    req_stall_o     = 1'b1;
    res_valid_o     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        req_stall_o = 1'b0;
        if (req_valid_i) begin
          if (req_i.opcode == OP_CLEAR) begin
            present_d = '0;
            rhs_d     = '0;
            rank_d    = '0;
            cons_d    = 1'b1;
            added_d   = 1'b0;
            state_d   = ST_DONE;
          end else begin
            row_d   = to_row(req_i.row_bits);
            b_d     = req_i.rhs_bit;
            cnt_d   = '0;
            state_d = ST_FWD;
          end
        end
      end
      ST_FWD: begin
        if (cnt_q != '0 && present_q[pidx] && row_q[pidx]) begin
          row_d = row_q ^ rdata_i;
          b_d   = b_q ^ rhs_q[pidx];
        end
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          state_d = ST_PIVOT;
        end
      end
      ST_PIVOT: begin
        cnt_d = '0;
        if (row_q == '0) begin
          cons_d  = ~b_q;
          added_d = 1'b0;
          state_d = ST_DONE;
        end else begin
          lead_d  = row_q & (~row_q + 1'b1);
          state_d = ST_BACK;
        end
      end
      ST_BACK: begin
        // rewrite the row read last cycle while the next one is read
        if (cnt_q != '0 && present_q[pidx] && ((rdata_i & lead_q) != '0)) begin
          mem_req_o.we = 1'b1;
          rhs_d[pidx]  = rhs_q[pidx] ^ b_q;
        end
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          state_d = ST_INS;
        end
      end
      ST_INS: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = onehot_idx(lead_q);
        mem_req_o.wdata = row_q;
        present_d       = present_q | lead_q;
        rhs_d           = (rhs_q & ~lead_q) | (b_q ? lead_q : '0);
        rank_d          = rank_q + 1'b1;
        cons_d          = 1'b1;
        added_d         = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.consistent = cons_q;
  assign res_o.new_pivot  = added_q;
  assign res_o.rank       = RANK_W'(rank_q);
  assign res_o.solution   = to_field(present_q & rhs_q);

endmodule

// ----- design/gir_checker.sv -----
// gir_checker: port-level assertions for gf2_incremental_row_echelon
// depends on gir_pkg; bound to the top level below

module gir_checker import gir_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input gir_rsp_t out_rsp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  a_pivot_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.new_pivot |-> out_rsp_o.consistent)
    else $error("new pivot reported inconsistent");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous one in flight");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped without handshake");

endmodule

bind gf2_incremental_row_echelon gir_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

// ----- tb/sv/gf2_echelon_checker.sv -----
// gf2_echelon_checker: watches the request and result channels of the gf2 row echelon block,
// keeps its own echelon store to predict each result and compares field by field
// depends on gir_pkg
`timescale 1ns / 1ps

module gf2_echelon_checker import gir_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  logic     req_stall_i,
  input  gir_req_t req_i,
  input  logic     rsp_valid_i,
  input  logic     rsp_stall_i,
  input  gir_rsp_t rsp_i,
  output int       fail_cnt_o,
  output int       pending_o
);

  gir_row_t echelon_rows [NUM_VARS];
  gir_row_t echelon_rhs;
  gir_row_t pivot_mask;
  gir_rsp_t expected_rsps [$];
  gir_rsp_t want_rsp;
  gir_rsp_t next_rsp;
  int       errors;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  function automatic void clear_store();
    for (int c = 0; c < NUM_VARS; c++) begin
      echelon_rows[c] = '0;
    end
    echelon_rhs = '0;
    pivot_mask  = '0;
  endfunction

  function automatic gir_rsp_t solve_equation(gir_req_t r);
    gir_row_t row;
    logic     rhs;
    int       lead;
    gir_rsp_t rsp;
    rsp = '0;
    rsp.consistent = 1'b1;
    if (r.opcode == OP_CLEAR) begin
      clear_store();
    end else begin
      row = gir_row_t'(r.row_bits);
      rhs = r.rhs_bit;
      // forward reduction against every stored pivot row
      for (int c = 0; c < NUM_VARS; c++) begin
        if (pivot_mask[c] && row[c]) begin
          row ^= echelon_rows[c];
          rhs ^= echelon_rhs[c];
        end
      end
      if (row == '0) begin
        rsp.consistent = !rhs;
      end else begin
        lead = 0;
        while (!row[lead]) begin
          lead++;
        end
        // keep the store in reduced form
        for (int c = 0; c < NUM_VARS; c++) begin
          if (pivot_mask[c] && echelon_rows[c][lead]) begin
            echelon_rows[c] ^= row;
            echelon_rhs[c]  ^= rhs;
          end
        end
        echelon_rows[lead] = row;
        echelon_rhs[lead]  = rhs;
        pivot_mask[lead]   = 1'b1;
        rsp.new_pivot      = 1'b1;
      end
    end
    rsp.rank     = RANK_W'($countones(pivot_mask));
    rsp.solution = pivot_mask & echelon_rhs;
    return rsp;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_store();
      expected_rsps.delete();
    end else begin
      if (req_valid_i && !req_stall_i) begin
        next_rsp      = solve_equation(req_i);
        expected_rsps = {expected_rsps, next_rsp};
      end
      if (rsp_valid_i && !rsp_stall_i) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch($sformatf("result %h with no request outstanding", rsp_i));
        end else begin
          want_rsp = expected_rsps.pop_front();
          if (rsp_i.consistent !== want_rsp.consistent) begin
            report_mismatch($sformatf("wrong consistent: got %b want %b",
                                      rsp_i.consistent, want_rsp.consistent));
          end
          if (rsp_i.new_pivot !== want_rsp.new_pivot) begin
            report_mismatch($sformatf("wrong new_pivot: got %b want %b",
                                      rsp_i.new_pivot, want_rsp.new_pivot));
          end
          if (rsp_i.rank !== want_rsp.rank) begin
            report_mismatch($sformatf("wrong rank: got %0d want %0d",
                                      rsp_i.rank, want_rsp.rank));
          end
          if (rsp_i.solution !== want_rsp.solution) begin
            report_mismatch($sformatf("wrong solution: got %h want %h",
                                      rsp_i.solution, want_rsp.solution));
          end
        end
      end
    end
    pending_o  <= expected_rsps.size();
    fail_cnt_o <= errors;
  end

endmodule

// ----- tb/sv/gf2_incremental_row_echelon_tb.sv -----
// gf2_incremental_row_echelon_tb: clock, reset, request and result-side stimulus and verdict
// drives directed then random parity equations into the block; checking is in gf2_echelon_checker
// depends on gir_pkg, gf2_echelon_checker and gf2_incremental_row_echelon
`timescale 1ns / 1ps

module gf2_incremental_row_echelon_tb;
  import gir_pkg::*;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 2 * NUM_VARS + 10;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  gir_req_t in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  gir_rsp_t out_rsp_o;

  int       fail_cnt;
  int       pending;
  int       quiet_cycles;
  logic     calm;
  logic     hold_req;
  gir_row_t secret;
  gir_row_t history [$];

  always #2 clk_i = ~clk_i;

  gf2_incremental_row_echelon dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  gf2_echelon_checker echelon_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_stall_i(in_stall_o),
    .req_i      (in_req_i),
    .rsp_valid_i(out_valid_o),
    .rsp_stall_i(out_stall_i),
    .rsp_i      (out_rsp_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  task automatic send_equation(input gir_op_e op, input logic [FIELD_W-1:0] row,
                               input logic rhs);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_req_i.opcode   <= op;
    in_req_i.row_bits <= row;
    in_req_i.rhs_bit  <= rhs;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic send_random_equation();
    int       pick;
    gir_row_t row;
    logic     flip;
    pick = $urandom_range(99);
    if (pick < 2) begin
      history.delete();
      secret = $urandom();
      send_equation(OP_CLEAR, $urandom(), 1'($urandom_range(1)));
    end else begin
      row  = '0;
      flip = 1'b0;
      if (pick < 5) begin
        flip = 1'($urandom_range(1));
      end else if (pick < 30 && history.size() != 0) begin
        // combination of earlier rows is always dependent
        repeat ($urandom_range(4, 1)) begin
          row ^= history[$urandom_range(history.size() - 1)];
        end
        flip = ($urandom_range(99) < 35);
      end else if (pick < 50) begin
        repeat ($urandom_range(3, 1)) begin
          row[$urandom_range(NUM_VARS - 1)] = 1'b1;
        end
      end else if (pick < 54) begin
        row  = $urandom();
        flip = 1'($urandom_range(1));
      end else begin
        row = $urandom();
      end
      history = {history, row};
      if (history.size() > 48) begin
        void'(history.pop_front());
      end
      send_equation(OP_ADD, row, (^(row & secret)) ^ flip);
    end
  endtask

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req    <= 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= !calm && ($urandom_range(99) < 25);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("gf2_incremental_row_echelon: mismatch");
    $finish;
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    calm       <= 1'b0;
    hold_req   <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // clear with ignored fields set, zero rows, extreme rows, back-reduction, dependents
    send_equation(OP_CLEAR, 32'hffff_ffff, 1'b1);
    send_equation(OP_ADD,   32'h0000_0000, 1'b0);
    send_equation(OP_ADD,   32'h0000_0000, 1'b1);
    send_equation(OP_ADD,   32'hffff_ffff, 1'b1);
    send_equation(OP_ADD,   32'h8000_0000, 1'b0);
    send_equation(OP_ADD,   32'h0000_0001, 1'b1);
    send_equation(OP_ADD,   32'hffff_ffff, 1'b1);
    send_equation(OP_ADD,   32'hffff_ffff, 1'b0);
    send_equation(OP_ADD,   32'h7fff_fffe, 1'b0);
    send_equation(OP_ADD,   32'h5555_5555, 1'b1);
    send_equation(OP_ADD,   32'haaaa_aaaa, 1'b0);
    send_equation(OP_ADD,   32'h0000_0000, 1'b0);
    send_equation(OP_CLEAR, 32'h0000_0000, 1'b0);
    send_equation(OP_ADD,   32'h0001_0000, 1'b1);
    send_equation(OP_ADD,   32'h0001_0000, 1'b1);
    send_equation(OP_ADD,   32'h0001_0000, 1'b0);
    send_equation(OP_ADD,   32'h0001_8000, 1'b0);
    send_equation(OP_CLEAR, 32'hffff_ffff, 1'b0);
    wait_for_results();

    secret = $urandom();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 400) begin
        hold_req <= 1'b1;
      end
      if (i == 600) begin
        calm <= 1'b1;
      end
      if (i == 800) begin
        calm <= 1'b0;
      end
      if (i == 900) begin
        wait_for_results();
      end
      send_random_equation();
    end
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0 && pending == 0) begin
      $display("gf2_incremental_row_echelon: match");
    end else begin
      $display("gf2_incremental_row_echelon: mismatch");
    end
    $finish;
  end

endmodule
